@@ rtl/sfr_pkg.sv @@
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic [1:0] CFG_PATTERN     = 2'd0;
    localparam logic [1:0] CFG_MATCH_LEN   = 2'd1;
    localparam logic [1:0] CFG_REPLACE     = 2'd2;
    localparam logic [1:0] CFG_REPLACE_LEN = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [63:0] data;
    } t_cfg_wr;

    // one decision of the front end: 1 to 8 results to be sent out
    typedef struct packed {
        logic [63:0] bytes;   // first byte in bits 7..0
        logic [2:0]  nm1;     // result count minus one
        logic        marker;  // single empty result carrying only the end mark
        logic        last;
    } t_pkt;

endpackage

@@ rtl/stream_find_and_replace.sv @@
// Top level of the stream find-and-replace block.
// Takes one byte per cycle and replaces each leftmost, non-overlapping match of a
// 1 to 8 byte pattern with a 0 to 8 byte replacement. Each input beat is decided in
// the cycle it is accepted; the resulting bytes go into a 4-entry packet queue and
// leave one result per cycle while i_out_stall is low; the input rate is one beat per
// cycle as long as the output keeps up: a match with a long replacement or an
// end-of-stream flush yields up to 8 output beats, during which the queue absorbs
// further input until it fills and o_in_stall rises. Beats pass from the queue
// through the sequencer's packet register into the output register. A stream whose
// final step emits nothing ends in one beat with o_has_byte low and o_out_last high.
// Write configuration only while the block is idle; writing the pattern length
// drops the pending bytes.
module stream_find_and_replace
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_out_last
);

    t_cfg_wr cfg;
    logic    in_accept;
    logic    push;
    t_pkt    push_pkt;
    logic    q_full;
    logic    q_valid;
    t_pkt    q_pkt;
    logic    q_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    sfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_push   (push),
        .o_pkt    (push_pkt)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (push_pkt),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_pkt   (q_pkt)
    );

    sfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_pkt     (q_pkt),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_has_byte  (o_has_byte),
        .o_out_last  (o_out_last)
    );

    // an empty beat only ever closes a stream
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_byte |-> o_out_last)
        else $error("empty result without end mark");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_byte |-> o_out_byte == 8'd0)
        else $error("empty result carries nonzero byte");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

@@ rtl/sfr_front.sv @@
// Front end: pending window, pattern compare, and packet build per input beat.
module sfr_front
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic        o_push,
    output t_pkt        o_pkt
);

    logic [63:0] r_pattern;
    logic [3:0]  r_match_len;
    logic [63:0] r_replace;
    logic [3:0]  r_replace_len;
    logic [7:0]  r_win [7];
    logic [2:0]  r_count;

    logic [7:0]  n_win [7];
    logic [2:0]  n_count;

    logic [3:0]  len;
    logic [3:0]  rlen;
    logic [2:0]  c;
    logic [3:0]  cc;
    logic [7:0]  w [8];
    logic        full;
    logic        hit;
    logic [3:0]  n;
    logic [63:0] w_flat;

    always_comb begin
        if (r_match_len == 4'd0) begin
            len = 4'd1;
        end else if (r_match_len > 4'(PATTERN_MAX)) begin
            len = 4'(PATTERN_MAX);
        end else begin
            len = r_match_len;
        end
        rlen = (r_replace_len > 4'(REPLACE_MAX)) ? 4'(REPLACE_MAX) : r_replace_len;
    end

    always_comb begin
        c = (4'(r_count) > len - 4'd1) ? 3'(len - 4'd1) : r_count;
        cc = 4'(c) + 4'd1;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) == c) begin
                w[i] = i_byte;
            end else if (i < 7 && 3'(i) < c) begin
                w[i] = r_win[i < 7 ? i : 0];
            end else begin
                w[i] = 8'd0;
            end
            w_flat[8*i +: 8] = w[i];
        end
        full = (cc == len);
        hit  = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len && w[i] != r_pattern[8*i +: 8]) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_win   = r_win;
        n_count = r_count;
        if (full && hit) begin
            n = rlen;
            n_count = 3'd0;
        end else if (full) begin
            n = i_last ? len : 4'd1;
            for (int i = 0; i < 7; i++) begin
                n_win[i] = w[i + 1];
            end
            n_count = 3'(len - 4'd1);
        end else begin
            n = i_last ? cc : 4'd0;
            for (int i = 0; i < 7; i++) begin
                n_win[i] = w[i];
            end
            n_count = cc[2:0];
        end
        if (i_last) begin
            n_count = 3'd0;
        end
    end

    assign o_push        = i_accept && (n != 4'd0 || i_last);
    assign o_pkt.bytes   = (full && hit) ? r_replace : w_flat;
    assign o_pkt.nm1     = (n == 4'd0) ? 3'd0 : 3'(n - 4'd1);
    assign o_pkt.marker  = (n == 4'd0);
    assign o_pkt.last    = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern     <= '0;
            r_match_len   <= 4'd1;
            r_replace     <= '0;
            r_replace_len <= 4'd0;
            r_count       <= 3'd0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_PATTERN: r_pattern <= i_cfg.data;
                    CFG_MATCH_LEN: begin
                        r_match_len <= i_cfg.data[3:0];
                        r_count     <= 3'd0;
                    end
                    CFG_REPLACE:     r_replace     <= i_cfg.data;
                    CFG_REPLACE_LEN: r_replace_len <= i_cfg.data[3:0];
                    default: ;
                endcase
            end else if (i_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

@@ rtl/sfr_queue.sv @@
// Short packet queue between the front end and the output sequencer.
module sfr_queue
    import sfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_pkt o_pkt
);

    t_pkt                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_pkt   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

endmodule

@@ rtl/sfr_back.sv @@
// Output sequencer: walks each packet into the output register one result per cycle unless stalled.
module sfr_back
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_pkt       i_q_pkt,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_out_last
);

    logic        r_busy;
    t_pkt        r_pkt;
    logic [2:0]  r_idx;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_ohas;
    logic        r_olast;

    logic out_free;
    logic step;
    logic done;
    logic load;

    assign out_free = !r_ovalid || !i_out_stall;
    assign step     = r_busy && out_free;
    assign done     = step && (r_idx == r_pkt.nm1);
    assign load     = i_q_valid && (!r_busy || done);
    assign o_q_pop  = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (out_free) begin
                r_ovalid <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_obyte <= r_pkt.marker ? 8'd0 : r_pkt.bytes[8*r_idx +: 8];
            r_ohas  <= !r_pkt.marker;
            r_olast <= r_pkt.last && (r_idx == r_pkt.nm1);
        end
        if (load) begin
            r_pkt <= i_q_pkt;
            r_idx <= 3'd0;
        end else if (step) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_has_byte  = r_ohas;
    assign o_out_last  = r_olast;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for stream_find_and_replace: predictor scoreboard, drivers, stimulus.

typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
} t_out_beat;

// Tracks register values and the pending window, and predicts the output beats.
class replace_scoreboard;
    logic [63:0] pattern;
    logic [3:0]  match_len_reg;
    logic [63:0] repl;
    logic [3:0]  repl_len_reg;
    logic [7:0]  window [8];
    int          win_count;
    t_out_beat   expected_beats [$];
    int          errors;

    function new();
        pattern       = '0;
        match_len_reg = 4'd1;
        repl          = '0;
        repl_len_reg  = 4'd0;
        errors        = 0;
        clear_window();
    endfunction

    function void clear_window();
        foreach (window[i]) window[i] = 8'h00;
        win_count = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [63:0] data);
        case (idx)
            sfr_pkg::CFG_PATTERN:     pattern = data;
            sfr_pkg::CFG_MATCH_LEN: begin
                match_len_reg = data[3:0];
                clear_window();
            end
            sfr_pkg::CFG_REPLACE:     repl = data;
            sfr_pkg::CFG_REPLACE_LEN: repl_len_reg = data[3:0];
            default: ;
        endcase
    endfunction

    function void push_beat(logic [7:0] data, logic has_byte);
        t_out_beat beat;
        beat.data     = data;
        beat.has_byte = has_byte;
        beat.last     = 1'b0;
        expected_beats = {expected_beats, beat};
    endfunction

    // Predicts the output beats caused by one accepted input beat.
    function void note_byte(logic [7:0] in_byte, logic in_last);
        logic [7:0] w [8];
        int         len;
        int         rl;
        int         c;
        int         base;
        bit         hit;
        len  = (match_len_reg == 0) ? 1 : int'(match_len_reg);
        if (len > sfr_pkg::PATTERN_MAX) len = sfr_pkg::PATTERN_MAX;
        rl   = int'(repl_len_reg);
        if (rl > sfr_pkg::REPLACE_MAX) rl = sfr_pkg::REPLACE_MAX;
        base = expected_beats.size();
        c    = win_count;
        if (c > len - 1) c = len - 1;
        w    = window;
        w[c] = in_byte;
        c++;

        if (c == len) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++)
                if (w[i] != pattern[8*i +: 8]) hit = 1'b0;
            if (hit) begin
                for (int i = 0; i < rl; i++) push_beat(repl[8*i +: 8], 1'b1);
                c = 0;
            end else begin
                push_beat(w[0], 1'b1);
                for (int i = 1; i < c; i++) w[i-1] = w[i];
                c--;
            end
        end

        if (in_last) begin
            for (int i = 0; i < c; i++) push_beat(w[i], 1'b1);
            c = 0;
            // nothing left to say: a lone end marker closes the stream
            if (expected_beats.size() == base) push_beat(8'h00, 1'b0);
            expected_beats[expected_beats.size()-1].last = 1'b1;
        end

        for (int i = 0; i < 8; i++) window[i] = (i < c) ? w[i] : 8'h00;
        win_count = c;
    endfunction

    function void check_beat(logic [7:0] data, logic has_byte, logic last);
        t_out_beat exp_beat;
        if (expected_beats.size() == 0) begin
            $error("unexpected output beat: out_byte 'h%02h has_byte %0b out_last %0b",
                   data, has_byte, last);
            errors++;
            return;
        end
        exp_beat = expected_beats.pop_front();
        if (data !== exp_beat.data) begin
            $error("out_byte: expected 'h%02h, got 'h%02h", exp_beat.data, data);
            errors++;
        end
        if (has_byte !== exp_beat.has_byte) begin
            $error("has_byte: expected %0b, got %0b", exp_beat.has_byte, has_byte);
            errors++;
        end
        if (last !== exp_beat.last) begin
            $error("out_last: expected %0b, got %0b", exp_beat.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction
endclass

module testbench;
    import sfr_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_has_byte;
    logic        o_out_last;

    replace_scoreboard sb = new();

    int send_mode = 2;
    int recv_mode = 2;
    int hold_req  = 0;
    int idle_cycles = 0;

    stream_find_and_replace u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_has_byte  (o_has_byte),
        .o_out_last  (o_out_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mode 0: never wait, 1: wait 0..19 every time, 2: wait now and then
    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 19);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        endcase
    endfunction

    // Monitor and watchdog
    always @(posedge i_clk) begin
        logic cfg_acc;
        logic in_acc;
        logic out_acc;
        if (i_rst_n) begin
            cfg_acc = i_cfg_valid && (o_cfg_ready === 1'b1);
            in_acc  = i_in_valid && (o_in_stall === 1'b0);
            out_acc = (o_out_valid === 1'b1) && !i_out_stall;
            if (cfg_acc) sb.note_config(i_cfg_index, i_cfg_data);
            if (in_acc)  sb.note_byte(i_in_byte, i_in_last);
            if (out_acc) sb.check_beat(o_out_byte, o_has_byte, o_out_last);
            if (cfg_acc || in_acc || out_acc) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    // Output side: random stalls per beat, plus long hold-offs on request
    initial begin
        int k;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_req) @(negedge i_clk);
                hold_req = 0;
            end
            k = draw_wait(recv_mode);
            if (k > 0) begin
                i_out_stall <= 1'b1;
                repeat (k) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1 && hold_req == 0);
        end
    end

    // Called at a falling edge; returns at the falling edge after the write.
    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [63:0] pat, input logic [63:0] mlen,
                               input logic [63:0] rep, input logic [63:0] rlen);
        cfg_write(CFG_PATTERN, pat);
        cfg_write(CFG_MATCH_LEN, mlen);
        cfg_write(CFG_REPLACE, rep);
        cfg_write(CFG_REPLACE_LEN, rlen);
        i_cfg_valid <= 1'b0;
    endtask

    // Called at a falling edge; holds the beat until it is taken.
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic drain(input int extra);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // Streams built mostly from whole and partial copies of the pattern.
    task automatic play_text(input logic [63:0] pat, input int len, input int n_items,
                             input int pause_at);
        logic [7:0] text [$];
        bit         ends [$];
        int         kind;
        int         span;
        while (text.size() < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                span = len;
            end else if (kind < 6) begin
                span = (len > 1) ? $urandom_range(1, len - 1) : 1;
            end else begin
                span = 0;
            end
            for (int j = 0; j < span; j++) begin
                text = {text, pat[8*j +: 8]};
                ends = {ends, 1'b0};
            end
            if (kind >= 6 && kind < 8) begin
                span = $urandom_range(0, len - 1);
                text = {text, pat[8*span +: 8]};
                ends = {ends, 1'b0};
            end else if (kind >= 8) begin
                text = {text, 8'($urandom_range(0, 255))};
                ends = {ends, 1'b0};
            end
            if ($urandom_range(0, 5) == 0) ends[ends.size()-1] = 1'b1;
        end
        ends[ends.size()-1] = 1'b1;
        foreach (text[i]) begin
            if (i == pause_at) drain(0);
            send_beat(text[i], ends[i]);
        end
    endtask

    initial begin
        logic [63:0] pat;
        logic [63:0] mdata;
        logic [63:0] rdata;
        int          raw_len;
        int          raw_rlen;
        int          eff_len;

        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PATTERN;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_in_last   = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: one-byte zero pattern deleted; last beat leaves only the marker
        send_beat(8'h00, 1'b0);
        send_beat(8'h5A, 1'b0);
        send_beat(8'h00, 1'b1);
        drain(SETTLE_CYCLES);

        // two-byte pattern; stream ends with one byte still pending in the window
        load_config(64'h6261, 64'h2, 64'h5A5958, 64'h3);
        send_beat(8'h61, 1'b0);
        send_beat(8'h61, 1'b0);
        send_beat(8'h62, 1'b0);
        send_beat(8'h63, 1'b1);
        send_beat(8'h61, 1'b0);
        drain(SETTLE_CYCLES);

        // length 15 clamps to 8, replacement length 12 clamps to 8;
        // the length write must drop the pending byte
        pat = 64'h80FF_0102_7F00_FE01;
        load_config(pat, 64'hF, 64'hFFEE_DDCC_BBAA_0099, 64'hC);
        for (int i = 0; i < 8; i++) send_beat(pat[8*i +: 8], 1'b0);
        for (int i = 0; i < 7; i++) send_beat(pat[8*i +: 8], 1'b0);
        send_beat(8'h00, 1'b1);   // near miss, then full flush
        drain(SETTLE_CYCLES);

        // length 0 acts as 1
        load_config(64'hFF, 64'hA5A5_0000_0000_0000, 64'h00, 64'h1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        drain(SETTLE_CYCLES);

        for (int ph = 0; ph < 7; ph++) begin
            pat       = {$urandom(), $urandom()};
            mdata     = {$urandom(), $urandom()};
            rdata     = {$urandom(), $urandom()};
            raw_len   = $urandom_range(1, 8);
            raw_rlen  = $urandom_range(0, 8);
            send_mode = $urandom_range(0, 2);
            recv_mode = $urandom_range(0, 2);
            case (ph)
                0: begin
                    raw_len   = 1;
                    raw_rlen  = 8;
                    send_mode = 0;
                    recv_mode = 0;
                end
                1: begin
                    raw_len   = 8;
                    raw_rlen  = 0;
                    send_mode = 1;
                    recv_mode = 1;
                end
                2: begin
                    raw_len   = 1;
                    raw_rlen  = 8;
                    send_mode = 0;
                end
                4: begin
                    raw_len  = $urandom_range(9, 15);
                    raw_rlen = $urandom_range(9, 15);
                end
                5: raw_len = 0;
                default: ;
            endcase
            mdata[3:0] = 4'(raw_len);
            rdata[3:0] = 4'(raw_rlen);
            eff_len = (raw_len == 0) ? 1 : ((raw_len > PATTERN_MAX) ? PATTERN_MAX : raw_len);
            load_config(pat, mdata, {$urandom(), $urandom()}, rdata);
            if (ph == 2) hold_req = HOLD_CYCLES;   // back up the output while input streams
            play_text(pat, eff_len, 27, (ph == 3) ? 13 : -1);
            drain(SETTLE_CYCLES);
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
